>>> hw/rtl/sdrhdr_pkg.sv
// Shared types and constants for the control header builder.
// Used by sdrhdr_cfg_regs and sdr_control_header_builder; no dependencies.
`timescale 1ns / 1ps

package sdrhdr_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned BANK_W     = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_SOURCE       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE_CODE   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RX_OPTIONS         = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RX_ANTENNA_BITS    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TX_ANTENNA_BITS    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RX_HIGHPASS_SELECT = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TX_LOWPASS_SELECT  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RX_ATTENUATION     = 4'd7;

  localparam logic [5:0] RX_OPTIONS_RESET = 6'd16;

  // action codes
  localparam logic ACT_ROTATE   = 1'b0;
  localparam logic ACT_EXPLICIT = 1'b1;

  // banks
  localparam logic [BANK_W-1:0] BANK_GENERAL = 4'd0;
  localparam logic [BANK_W-1:0] BANK_TX_FREQ = 4'd1;
  localparam logic [BANK_W-1:0] BANK_RX0_FREQ = 4'd2;
  localparam logic [BANK_W-1:0] BANK_RX1_FREQ = 4'd3;
  localparam logic [BANK_W-1:0] BANK_DRIVE   = 4'd9;
  localparam logic [BANK_W-1:0] BANK_ATTEN   = 4'd10;
  localparam logic [BANK_W-1:0] LAST_BANK    = 4'd10;

  localparam logic [7:0] DRIVE_C2 = 8'h40;
  localparam logic [7:0] ATTEN_C2 = 8'h17;

  // filter band edges in Hz
  localparam logic [31:0] HPF_EDGE_1 = 32'd1500000;
  localparam logic [31:0] HPF_EDGE_2 = 32'd6500000;
  localparam logic [31:0] HPF_EDGE_3 = 32'd9500000;
  localparam logic [31:0] HPF_EDGE_4 = 32'd13000000;
  localparam logic [31:0] HPF_EDGE_5 = 32'd20000000;
  localparam logic [31:0] HPF_EDGE_6 = 32'd50000000;
  localparam logic [31:0] LPF_EDGE_1 = 32'd30000000;
  localparam logic [31:0] LPF_EDGE_2 = 32'd19000000;
  localparam logic [31:0] LPF_EDGE_3 = 32'd14900000;
  localparam logic [31:0] LPF_EDGE_4 = 32'd9900000;
  localparam logic [31:0] LPF_EDGE_5 = 32'd4900000;
  localparam logic [31:0] LPF_EDGE_6 = 32'd3400000;

  typedef struct packed {
    logic [5:0] clock_source;
    logic [1:0] sample_rate_code;
    logic [5:0] rx_options;
    logic [7:0] rx_antenna_bits;
    logic [7:0] tx_antenna_bits;
    logic [6:0] rx_highpass_select;
    logic [6:0] tx_lowpass_select;
    logic [4:0] rx_attenuation;
  } sdrhdr_cfg_t;

  typedef struct packed {
    logic              action;
    logic [BANK_W-1:0] bank_number;
    logic              ptt_on;
    logic [31:0]       tx_frequency;
    logic [31:0]       rx0_frequency;
    logic [31:0]       rx1_frequency;
    logic [7:0]        drive_level;
  } sdrhdr_req_t;

  typedef struct packed {
    logic [7:0]        c0_command;
    logic [7:0]        c1_byte;
    logic [7:0]        c2_byte;
    logic [7:0]        c3_byte;
    logic [7:0]        c4_byte;
    logic [BANK_W-1:0] bank_used;
  } sdrhdr_rsp_t;

endpackage

>>> hw/rtl/sdrhdr_cfg_regs.sv
// Configuration register file for the control header builder.
// Depends on sdrhdr_pkg; writes to unknown indexes are dropped.
`timescale 1ns / 1ps

module sdrhdr_cfg_regs import sdrhdr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output sdrhdr_cfg_t           cfg_o
);

  sdrhdr_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CLOCK_SOURCE:       cfg_d.clock_source       = cfg_data_i[5:0];
        REG_SAMPLE_RATE_CODE:   cfg_d.sample_rate_code   = cfg_data_i[1:0];
        REG_RX_OPTIONS:         cfg_d.rx_options         = cfg_data_i[5:0];
        REG_RX_ANTENNA_BITS:    cfg_d.rx_antenna_bits    = cfg_data_i;
        REG_TX_ANTENNA_BITS:    cfg_d.tx_antenna_bits    = cfg_data_i;
        REG_RX_HIGHPASS_SELECT: cfg_d.rx_highpass_select = cfg_data_i[6:0];
        REG_TX_LOWPASS_SELECT:  cfg_d.tx_lowpass_select  = cfg_data_i[6:0];
        REG_RX_ATTENUATION:     cfg_d.rx_attenuation     = cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{clock_source:       '0,
                 sample_rate_code:   '0,
                 rx_options:         RX_OPTIONS_RESET,
                 rx_antenna_bits:    '0,
                 tx_antenna_bits:    '0,
                 rx_highpass_select: '0,
                 tx_lowpass_select:  '0,
                 rx_attenuation:     '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/sdr_control_header_builder.sv
// Top level of the control header builder: request register, encoder, result register.
// Depends on sdrhdr_pkg and sdrhdr_cfg_regs.
`timescale 1ns / 1ps

// Each accepted request yields one five-byte control header (C0..C4) plus the
// bank that was encoded. Requests are taken one per clock while in_stall_o
// is low; each request is held in the request register, then encoded
// into the result register that drives the output, and both stages hold
// under out_stall_i. Action 0 advances the rotating bank (1..10, then 0) at
// acceptance; action 1 encodes the given bank.
// Configuration writes are always ready and take effect on the next cycle;
// write them only while no request is in flight.
module sdr_control_header_builder import sdrhdr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sdrhdr_req_t           in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sdrhdr_rsp_t           out_rsp_o
);

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic              ptt;
    logic [31:0]       txf;
    logic [31:0]       rx0;
    logic [31:0]       rx1;
    logic [7:0]        drive;
  } sdrhdr_stage_t;

  function automatic logic [6:0] auto_highpass(input logic [31:0] f);
    logic [6:0] r;
    if (f < HPF_EDGE_1)      r = 7'h20;
    else if (f < HPF_EDGE_2) r = 7'h10;
    else if (f < HPF_EDGE_3) r = 7'h08;
    else if (f < HPF_EDGE_4) r = 7'h04;
    else if (f < HPF_EDGE_5) r = 7'h01;
    else if (f < HPF_EDGE_6) r = 7'h02;
    else                     r = 7'h40;
    return r;
  endfunction

  function automatic logic [6:0] auto_lowpass(input logic [31:0] f);
    logic [6:0] r;
    if (f > LPF_EDGE_1)      r = 7'h10;
    else if (f > LPF_EDGE_2) r = 7'h20;
    else if (f > LPF_EDGE_3) r = 7'h40;
    else if (f > LPF_EDGE_4) r = 7'h01;
    else if (f > LPF_EDGE_5) r = 7'h02;
    else if (f > LPF_EDGE_6) r = 7'h04;
    else                     r = 7'h08;
    return r;
  endfunction

  sdrhdr_cfg_t cfg;

  sdrhdr_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign cfg_ready_o = 1'b1;

  logic              s1_valid_q, s1_valid_d;
  logic              s2_valid_q, s2_valid_d;
  logic [BANK_W-1:0] rot_q, rot_d, rot_next;
  sdrhdr_stage_t     s1_q, s1_d;
  sdrhdr_rsp_t       s2_q, s2_d;
  logic              s2_adv, in_acc;

  assign s2_adv     = !s2_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s2_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign rot_next   = (rot_q == LAST_BANK) ? BANK_GENERAL : rot_q + 4'd1;

  always_comb begin
    rot_d      = rot_q;
    s1_valid_d = s2_adv ? 1'b0 : s1_valid_q;
    s2_valid_d = s2_adv ? s1_valid_q : s2_valid_q;
    s1_d.ptt   = in_req_i.ptt_on;
    s1_d.txf   = in_req_i.tx_frequency;
    s1_d.rx0   = in_req_i.rx0_frequency;
    s1_d.rx1   = in_req_i.rx1_frequency;
    s1_d.drive = in_req_i.drive_level;
    s1_d.bank  = in_req_i.bank_number;
    if (in_acc) begin
      s1_valid_d = 1'b1;
      if (in_req_i.action == ACT_ROTATE) begin
        rot_d     = rot_next;
        s1_d.bank = rot_next;
      end
    end
  end

  // encoder
  always_comb begin
    s2_d            = '0;
    s2_d.bank_used  = s1_q.bank;
    s2_d.c0_command = {3'b000, s1_q.bank, s1_q.ptt};
    case (s1_q.bank)
      BANK_GENERAL: begin
        s2_d.c1_byte = {cfg.clock_source, cfg.sample_rate_code};
        s2_d.c3_byte = {3'b000, cfg.rx_options[2:0], 2'b00} | cfg.rx_antenna_bits;
        s2_d.c4_byte = {4'b0000, cfg.rx_options[3], cfg.rx_options[4], 2'b00}
                       | cfg.tx_antenna_bits;
      end
      BANK_TX_FREQ: begin
        {s2_d.c1_byte, s2_d.c2_byte, s2_d.c3_byte, s2_d.c4_byte} = s1_q.txf;
      end
      BANK_RX0_FREQ: begin
        {s2_d.c1_byte, s2_d.c2_byte, s2_d.c3_byte, s2_d.c4_byte} = s1_q.rx0;
      end
      BANK_RX1_FREQ: begin
        {s2_d.c1_byte, s2_d.c2_byte, s2_d.c3_byte, s2_d.c4_byte} = s1_q.rx1;
      end
      BANK_DRIVE: begin
        s2_d.c1_byte = (cfg.rx_options[5] && !s1_q.ptt) ? 8'h00 : s1_q.drive;
        s2_d.c2_byte = DRIVE_C2;
        s2_d.c3_byte = {1'b0, (cfg.rx_highpass_select != 7'd0) ?
                              cfg.rx_highpass_select : auto_highpass(s1_q.rx0)};
        s2_d.c4_byte = {1'b0, (cfg.tx_lowpass_select != 7'd0) ?
                              cfg.tx_lowpass_select : auto_lowpass(s1_q.txf)};
      end
      BANK_ATTEN: begin
        s2_d.c2_byte = ATTEN_C2;
        s2_d.c4_byte = {3'b000, cfg.rx_attenuation};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      rot_q      <= BANK_GENERAL;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      rot_q      <= rot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s2_adv && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_rsp_o   = s2_q;

  // terse checks
  a_rot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_q <= LAST_BANK)
    else $error("rotating bank out of range");

  a_rot_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_req_i.action == ACT_ROTATE) |=> s1_q.bank == $past(rot_next))
    else $error("rotating bank not used for request");

  a_c0_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.c0_command[4:1] == out_rsp_o.bank_used) &&
                    (out_rsp_o.c0_command[7:5] == 3'b000))
    else $error("C0 does not match bank");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_adv |=> s1_valid_q && $stable(s1_q))
    else $error("request stage lost while stalled");

  a_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.bank_used > LAST_BANK) |->
      (out_rsp_o.c1_byte == 8'h00) && (out_rsp_o.c2_byte == 8'h00) &&
      (out_rsp_o.c3_byte == 8'h00) && (out_rsp_o.c4_byte == 8'h00))
    else $error("unused bank carries data");

endmodule
